### src/acbpi_pkg.sv
`default_nettype none

package acbpi_pkg;

    // field widths
    localparam int V_W    = 16;
    localparam int ANG_W  = 16;
    localparam int ADM_W  = 24;
    localparam int OUT_W  = 48;

    // angle resolution and accumulator width
    localparam int ANGLE_BITS = 16;
    localparam int SUM_BITS   = 48;

    // angle difference mask, full circle of 2^ANGLE_BITS
    localparam logic [31:0] ANGLE_MASK = (32'd1 << ANGLE_BITS) - 32'd1;

    // cordic rotator
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W     = 34;
    localparam int TRIG_W       = 18;

    typedef struct packed {
        logic              load;
        logic              run;
        logic [STEP_W-1:0] idx;
    } t_cordic_ctl;

endpackage

`default_nettype wire

### src/acbpi_cordic.sv
`default_nettype none

module acbpi_cordic import acbpi_pkg::*; (
    input  logic                     i_clk,
    input  t_cordic_ctl              i_ctl,
    input  logic [31:0]              i_angle,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);

    localparam logic signed [CORDIC_W-1:0] GAIN     = 652032874;
    localparam logic signed [CORDIC_W-1:0] TRIG_MAX = 65536;
    localparam logic signed [CORDIC_W-1:0] TRIG_MIN = -65536;

    function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051D;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // floor shift to q.16 and clamp to one unit
    function automatic logic signed [TRIG_W-1:0] clamp_trig(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] t;
        t = v >>> 14;
        if (t > TRIG_MAX) begin
            t = TRIG_MAX;
        end else if (t < TRIG_MIN) begin
            t = TRIG_MIN;
        end
        return t[TRIG_W-1:0];
    endfunction

    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic                       r_flip;

    logic [1:0]                 top_q;
    logic                       flip_in;
    logic [31:0]                ang_adj;
    logic signed [CORDIC_W-1:0] z_in;
    logic signed [CORDIC_W-1:0] xs, ys, at;
    logic signed [CORDIC_W-1:0] x_out, y_out;

    // left half circle turned by half a turn, results negated at the end
    assign top_q   = i_angle[31:30];
    assign flip_in = (top_q == 2'b01) || (top_q == 2'b10);
    assign ang_adj = {i_angle[31] ^ flip_in, i_angle[30:0]};
    assign z_in    = CORDIC_W'($signed(ang_adj));

    assign xs = r_x >>> i_ctl.idx;
    assign ys = r_y >>> i_ctl.idx;
    assign at = CORDIC_W'($signed({1'b0, atan_lut(i_ctl.idx)}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x    <= GAIN;
            r_y    <= '0;
            r_z    <= z_in;
            r_flip <= flip_in;
        end else if (i_ctl.run) begin
            if (r_z >= 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign x_out = r_flip ? -r_x : r_x;
    assign y_out = r_flip ? -r_y : r_y;
    assign o_cos = clamp_trig(x_out);
    assign o_sin = clamp_trig(y_out);

endmodule

`default_nettype wire

### src/ac_bus_power_injection.sv
// AC bus power injection: streams the lines of one bus and returns the active power P and
// reactive power Q injected there. Each item carries the bus voltage, angle and shunt G/B
// together with one attached line (G, B, far voltage, far angle). An item with tuser bit 0
// set restarts the sums with G*V^2 and -B*V^2; an item with tuser bit 1 set adds the line
// term V*Vk*(G*cos d + B*sin d) to P and V*Vk*(G*sin d - B*cos d) to Q, d being the angle
// difference; tlast emits one result with both sums and an overflow flag. Sums saturate to
// the accumulator range. One item is worked on at a time: s_axis_tready is high only in the
// idle state. An item with a line term goes through 20 cordic iterations of the rotator,
// 8 slots of the shared multiplier for the trig factors and the final products, a result
// state and back to idle; the shunt products ride on the multiplier during the cordic
// iterations. An item without a line term goes from the shunt slots straight to the result
// state. A result waits in an output register, so a stalled master side holds up the block
// only at the end of the next bus.

`default_nettype none

module ac_bus_power_injection import acbpi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side, tdata from bit 0 up: v_node, angle_node, g_self, b_self, g_line, b_line,
    // v_other, angle_other
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // last_line
    input  logic [1:0]   s_axis_tuser,   // bit 0 first_line, bit 1 line_present
    // master side, tdata from bit 0 up: p_inject, q_inject
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // overflowed
);

    // multiplier and term widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 43;
    localparam int TERM_W  = 34;
    localparam int ADD_W   = ((SUM_BITS > TERM_W) ? SUM_BITS : TERM_W) + 1;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_LINE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // slots while the rotator runs
    localparam logic [STEP_W-1:0] R_ISSUE_VV  = STEP_W'(0);
    localparam logic [STEP_W-1:0] R_ISSUE_G   = STEP_W'(1);
    localparam logic [STEP_W-1:0] R_LOAD_P    = STEP_W'(2);
    localparam logic [STEP_W-1:0] R_LOAD_Q    = STEP_W'(3);
    localparam logic [STEP_W-1:0] R_TAKE_VVK  = STEP_W'(4);
    localparam logic [STEP_W-1:0] R_LAST      = STEP_W'(CORDIC_STEPS - 1);

    // slots of the line phase
    localparam logic [STEP_W-1:0] L_TRIG  = STEP_W'(0);
    localparam logic [STEP_W-1:0] L_GC    = STEP_W'(1);
    localparam logic [STEP_W-1:0] L_BS    = STEP_W'(2);
    localparam logic [STEP_W-1:0] L_FP    = STEP_W'(3);
    localparam logic [STEP_W-1:0] L_GS    = STEP_W'(4);
    localparam logic [STEP_W-1:0] L_FQ    = STEP_W'(5);
    localparam logic [STEP_W-1:0] L_ADD_P = STEP_W'(6);
    localparam logic [STEP_W-1:0] L_ADD_Q = STEP_W'(7);

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic                       ovf;
    } t_sat;

    // saturating add into the accumulator range
    function automatic t_sat sat_add(
        input logic signed [SUM_BITS-1:0] a,
        input logic signed [TERM_W-1:0]   b
    );
        logic signed [ADD_W-1:0] s;
        logic signed [ADD_W-1:0] hi;
        logic signed [ADD_W-1:0] lo;
        t_sat                    r;
        s  = ADD_W'(a) + ADD_W'(b);
        hi = ADD_W'(SUM_MAX);
        lo = ADD_W'(SUM_MIN);
        if (s > hi) begin
            r.sum = SUM_MAX;
            r.ovf = 1'b1;
        end else if (s < lo) begin
            r.sum = SUM_MIN;
            r.ovf = 1'b1;
        end else begin
            r.sum = s[SUM_BITS-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // low output bits of the sign-extended sum
    function automatic logic [OUT_W-1:0] to_out(input logic signed [SUM_BITS-1:0] s);
        logic signed [63:0] e;
        e = 64'(s);
        return e[OUT_W-1:0];
    endfunction

    // input fields
    logic                    in_first, in_line;
    logic [V_W-1:0]          in_v, in_vk;
    logic [ANG_W-1:0]        in_ang, in_ang_o;
    logic [31:0]             ang_diff, ang32;

    assign in_first = s_axis_tuser[0];
    assign in_line  = s_axis_tuser[1];
    assign in_v     = s_axis_tdata[15:0];
    assign in_ang   = s_axis_tdata[31:16];
    assign in_vk    = s_axis_tdata[143:128];
    assign in_ang_o = s_axis_tdata[159:144];

    // wrapped angle difference scaled to a 32-bit binary angle
    assign ang_diff = 32'(in_ang) - 32'(in_ang_o);
    assign ang32    = (ang_diff & ANGLE_MASK) << (32 - ANGLE_BITS);

    // control
    logic [1:0]                 r_state, n_state;
    logic [STEP_W-1:0]          r_cnt, n_cnt;
    logic                       accept;
    logic                       emit;

    // item registers
    logic                       r_first, r_last, r_line;
    logic [V_W-1:0]             r_v, r_vk;
    logic signed [ADM_W-1:0]    r_g, r_b, r_gl, r_bl;

    // datapath registers
    logic signed [PROD_W-1:0]   r_prod;
    logic [31:0]                r_vv;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [MUL_B_W-1:0]  r_fp, r_fq;
    logic signed [TRIG_W-1:0]   r_c, r_s;

    // accumulators
    logic signed [SUM_BITS-1:0] r_p_sum, n_p_sum;
    logic signed [SUM_BITS-1:0] r_q_sum, n_q_sum;
    logic                       r_sat, n_sat;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic [OUT_W-1:0]           r_out_p, r_out_q;
    logic                       r_out_ovf;

    // shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    // shared saturating adder
    logic signed [SUM_BITS-1:0] sat_a;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [TERM_W-1:0]   term;
    t_sat                       sat_r;

    // trig factor sums
    logic signed [ACC_W-1:0]    prod_lo;
    logic signed [ACC_W-1:0]    f_sum, f_dif;
    logic signed [ACC_W-1:0]    f_sum_sh, f_dif_sh;

    t_cordic_ctl                cordic_ctl;
    logic signed [TRIG_W-1:0]   cos_v, sin_v;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign emit          = (r_state == S_DONE) && r_last && (!r_out_valid || m_axis_tready);

    // rotator loads at acceptance and steps once per run cycle
    assign cordic_ctl.load = accept;
    assign cordic_ctl.run  = (r_state == S_RUN);
    assign cordic_ctl.idx  = r_cnt;

    acbpi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_ctl   (cordic_ctl),
        .i_angle (ang32),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    // multiplier operand selection by slot
    always_comb begin
        mul_a = MUL_A_W'(r_v);
        mul_b = MUL_B_W'(r_v);
        case (r_state)
            S_RUN: begin
                case (r_cnt)
                    R_ISSUE_G: begin
                        mul_a = MUL_A_W'(r_prod[31:0]);
                        mul_b = MUL_B_W'(r_g);
                    end
                    R_LOAD_P: begin
                        mul_a = MUL_A_W'(r_vv);
                        mul_b = -(MUL_B_W'(r_b));
                    end
                    R_LOAD_Q: begin
                        mul_a = MUL_A_W'(r_v);
                        mul_b = MUL_B_W'(r_vk);
                    end
                    default: begin
                        mul_a = MUL_A_W'(r_v);
                        mul_b = MUL_B_W'(r_v);
                    end
                endcase
            end
            S_LINE: begin
                case (r_cnt)
                    L_GC: begin
                        mul_a = MUL_A_W'(r_c);
                        mul_b = MUL_B_W'(r_gl);
                    end
                    L_BS: begin
                        mul_a = MUL_A_W'(r_s);
                        mul_b = MUL_B_W'(r_bl);
                    end
                    L_FP: begin
                        mul_a = MUL_A_W'(r_s);
                        mul_b = MUL_B_W'(r_gl);
                    end
                    L_GS: begin
                        mul_a = MUL_A_W'(r_c);
                        mul_b = MUL_B_W'(r_bl);
                    end
                    L_FQ: begin
                        mul_a = MUL_A_W'(r_vv);
                        mul_b = r_fp;
                    end
                    L_ADD_P: begin
                        mul_a = MUL_A_W'(r_vv);
                        mul_b = r_fq;
                    end
                    default: begin
                        mul_a = MUL_A_W'(r_v);
                        mul_b = MUL_B_W'(r_v);
                    end
                endcase
            end
            default: begin
                mul_a = MUL_A_W'(r_v);
                mul_b = MUL_B_W'(r_v);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product scaled by 2^-24 is the term for either sum
    assign prod_sh = r_prod >>> 24;
    assign term    = prod_sh[TERM_W-1:0];
    assign sat_a   = (r_state == S_RUN)                          ? SUM_BITS'(0) :
                     ((r_state == S_LINE) && (r_cnt == L_ADD_P)) ? r_p_sum      : r_q_sum;
    assign sat_r   = sat_add(sat_a, term);

    // trig factors (gl*c + bl*s) and (gl*s - bl*c), floor-shifted to q10.16
    assign prod_lo  = $signed(r_prod[ACC_W-1:0]);
    assign f_sum    = r_acc + prod_lo;
    assign f_dif    = r_acc - prod_lo;
    assign f_sum_sh = f_sum >>> 16;
    assign f_dif_sh = f_dif >>> 16;

    // sequencer and accumulators
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_p_sum     = r_p_sum;
        n_q_sum     = r_q_sum;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                // shunt terms restart the sums on the first item of a bus
                if (r_first && (r_cnt == R_LOAD_P)) begin
                    n_p_sum = sat_r.sum;
                    n_sat   = sat_r.ovf;
                end
                if (r_first && (r_cnt == R_LOAD_Q)) begin
                    n_q_sum = sat_r.sum;
                    n_sat   = r_sat || sat_r.ovf;
                end
                if ((r_cnt == R_LOAD_Q) && !r_line) begin
                    n_state = S_DONE;
                end else if (r_cnt == R_LAST) begin
                    n_state = S_LINE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_LINE: begin
                if (r_cnt == L_ADD_P) begin
                    n_p_sum = sat_r.sum;
                    n_sat   = r_sat || sat_r.ovf;
                end
                if (r_cnt == L_ADD_Q) begin
                    n_q_sum = sat_r.sum;
                    n_sat   = r_sat || sat_r.ovf;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_DONE: begin
                // a closing item holds here until the output register can take the result; others go back to idle
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (!r_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_p_sum     <= '0;
            r_q_sum     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_p_sum     <= n_p_sum;
            r_q_sum     <= n_q_sum;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    // item capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first <= in_first;
            r_last  <= s_axis_tlast;
            r_line  <= in_line;
            r_v     <= in_v;
            r_vk    <= in_vk;
            r_g     <= $signed(s_axis_tdata[55:32]);
            r_b     <= $signed(s_axis_tdata[79:56]);
            r_gl    <= $signed(s_axis_tdata[103:80]);
            r_bl    <= $signed(s_axis_tdata[127:104]);
        end

        r_prod <= mul_p;

        // v*v first, v*vk later, in the same register
        if ((r_state == S_RUN) && ((r_cnt == R_ISSUE_G) || (r_cnt == R_TAKE_VVK))) begin
            r_vv <= r_prod[31:0];
        end

        if ((r_state == S_LINE) && (r_cnt == L_TRIG)) begin
            r_c <= cos_v;
            r_s <= sin_v;
        end
        if ((r_state == S_LINE) && ((r_cnt == L_BS) || (r_cnt == L_GS))) begin
            r_acc <= prod_lo;
        end
        if ((r_state == S_LINE) && (r_cnt == L_FP)) begin
            r_fp <= f_sum_sh[MUL_B_W-1:0];
        end
        if ((r_state == S_LINE) && (r_cnt == L_FQ)) begin
            r_fq <= f_dif_sh[MUL_B_W-1:0];
        end

        if (emit) begin
            r_out_p   <= to_out(r_p_sum);
            r_out_q   <= to_out(r_q_sum);
            r_out_ovf <= r_sat;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_q, r_out_p};
    assign m_axis_tuser[0] = r_out_ovf;

    // an accepted item always starts the rotator phase at slot zero
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RUN) && (r_cnt == '0))
        else $error("accepted item did not start the run phase");

    // the iteration index never passes the last cordic step
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= R_LAST))
        else $error("cordic index out of range");

    // the line phase is entered only for items that carry a line
    a_line_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINE) |-> r_line)
        else $error("line phase without a line term");

    // a new result appears only after the last item of a bus
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past((r_state == S_DONE) && r_last))
        else $error("result without a closing item");

endmodule

`default_nettype wire

### sim/acbpi_checker.sv
`default_nettype none

module acbpi_checker import acbpi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [159:0] i_s_tdata,   // v_node, angle_node, g_self, b_self, g_line, b_line,
                                      // v_other, angle_other
    input  logic         i_s_tlast,   // last_line
    input  logic [1:0]   i_s_tuser,   // first_line, line_present
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [95:0]  i_m_tdata,   // p_inject, q_inject
    input  logic [0:0]   i_m_tuser,   // overflowed
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ROT_GAIN = 64'sd652032874;

    typedef struct packed {
        logic [OUT_W-1:0] p;
        logic [OUT_W-1:0] q;
        logic             ovf;
    } bus_power_t;

    bus_power_t power_q[$];

    longint p_acc;
    longint q_acc;
    logic   sat_flag;
    int     mismatches;
    int     results;

    // rotation angles of the cordic, q2.30 binary angle
    function automatic longint atan_step(input int k);
        case (k)
            0:       return 64'h20000000;
            1:       return 64'h12E4051D;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2F9;
            15:      return 64'h0000517C;
            16:      return 64'h000028BE;
            17:      return 64'h0000145F;
            18:      return 64'h00000A2F;
            default: return 64'h00000517;
        endcase
    endfunction

    // q2.30 down to q.16, bounded to one per unit
    function automatic longint trig_clamp(input longint v);
        longint r;
        r = v >>> 14;
        if (r > 65536)
            r = 65536;
        if (r < -65536)
            r = -65536;
        return r;
    endfunction

    function automatic void trig_rotate(input logic [31:0] ang, output longint c,
                                        output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, xs, ys;
        a    = ang;
        flip = 1'b0;
        // left half circle: turn by pi, negate afterwards
        if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
            a    = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        x = ROT_GAIN;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(k);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(k);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = trig_clamp(x);
        s = trig_clamp(y);
    endfunction

    function automatic longint sat_accumulate(input longint acc, input longint inc);
        longint hi, lo;
        hi = (64'sd1 <<< (SUM_BITS - 1)) - 1;
        lo = -hi - 1;
        if (inc > 0 && acc > hi - inc) begin
            sat_flag = 1'b1;
            return hi;
        end
        if (inc < 0 && acc < lo - inc) begin
            sat_flag = 1'b1;
            return lo;
        end
        return acc + inc;
    endfunction

    // advance the bus sums by one item, queue a result on last_line
    function automatic void predict_bus_power();
        longint      v, vk, vsq, vv, gs, bs, gl, bl, c, s, fp, fq;
        logic [31:0] diff;
        bus_power_t  r;
        v  = longint'(i_s_tdata[15:0]);
        gs = longint'($signed(i_s_tdata[55:32]));
        bs = longint'($signed(i_s_tdata[79:56]));
        gl = longint'($signed(i_s_tdata[103:80]));
        bl = longint'($signed(i_s_tdata[127:104]));
        vk = longint'(i_s_tdata[143:128]);
        if (i_s_tuser[0]) begin
            vsq      = v * v;
            sat_flag = 1'b0;
            p_acc    = sat_accumulate(0, (gs * vsq) >>> 24);
            q_acc    = sat_accumulate(0, (-(bs * vsq)) >>> 24);
        end
        if (i_s_tuser[1]) begin
            diff = ({16'd0, i_s_tdata[31:16]} - {16'd0, i_s_tdata[159:144]}) & ANGLE_MASK;
            trig_rotate(diff << (32 - ANGLE_BITS), c, s);
            fp    = (gl * c + bl * s) >>> 16;
            fq    = (gl * s - bl * c) >>> 16;
            vv    = v * vk;
            p_acc = sat_accumulate(p_acc, (vv * fp) >>> 24);
            q_acc = sat_accumulate(q_acc, (vv * fq) >>> 24);
        end
        if (i_s_tlast) begin
            r.p   = p_acc[OUT_W-1:0];
            r.q   = q_acc[OUT_W-1:0];
            r.ovf = sat_flag;
            power_q.insert(power_q.size(), r);
        end
    endfunction

    always @(posedge i_clk) begin
        bus_power_t want;
        if (!i_rst_n) begin
            p_acc      = 0;
            q_acc      = 0;
            sat_flag   = 1'b0;
            mismatches = 0;
            results    = 0;
            power_q.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                results++;
                if (power_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result p=%h q=%h ovf=%b", $time,
                             i_m_tdata[47:0], i_m_tdata[95:48], i_m_tuser[0]);
                end else begin
                    want = power_q.pop_front();
                    if (i_m_tdata[47:0] !== want.p) begin
                        mismatches++;
                        $display("%0t: p_inject expected %h actual %h", $time, want.p,
                                 i_m_tdata[47:0]);
                    end
                    if (i_m_tdata[95:48] !== want.q) begin
                        mismatches++;
                        $display("%0t: q_inject expected %h actual %h", $time, want.q,
                                 i_m_tdata[95:48]);
                    end
                    if (i_m_tuser[0] !== want.ovf) begin
                        mismatches++;
                        $display("%0t: overflowed expected %b actual %b", $time, want.ovf,
                                 i_m_tuser[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_bus_power();
        end
        o_fail_count   <= mismatches;
        o_pending      <= power_q.size();
        o_results_seen <= results;
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS   = 1900;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam logic [15:0] V_MAX          = 16'hFFFF;
    localparam logic [23:0] ADM_MAX        = 24'h7FFFFF;
    localparam logic [23:0] ADM_MIN        = 24'h800000;
    localparam logic [23:0] ADM_ONE        = 24'h010000;  // 1.0 in q8.16
    localparam logic [15:0] V_ONE          = 16'h1000;    // 1.0 in q4.12

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata  = '0;   // v_node, angle_node, g_self, b_self, g_line, b_line,
                                        // v_other, angle_other
    logic         s_axis_tlast  = 1'b0; // last_line
    logic [1:0]   s_axis_tuser  = '0;   // first_line, line_present
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;         // p_inject, q_inject
    logic [0:0]   m_axis_tuser;         // overflowed

    int fail_count;
    int pending;
    int results_seen;
    int items_sent;
    int buses_closed;
    int quiet_cycles = 0;
    // random idling on the sender and on the receiver
    logic gaps_on  = 1'b1;
    logic stall_on = 1'b1;

    ac_bus_power_injection dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    acbpi_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tlast      (s_axis_tlast),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tuser      (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: back-pressure drawn at random, tready low about ten percent of the time while stalls are enabled
    always @(posedge i_clk) begin
        m_axis_tready <= !stall_on || ($urandom_range(99) >= 10);
    end

    // watchdog: once the count of cycles with no handshake on either side reaches WATCHDOG_LIMIT, the run ends
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                     WATCHDOG_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // admittance: mostly full range, sometimes pinned to an extreme or zero
    function automatic logic [23:0] rand_adm();
        case ($urandom_range(9))
            0:       return ADM_MAX;
            1:       return ADM_MIN;
            2:       return '0;
            default: return 24'($urandom);
        endcase
    endfunction

    // voltage magnitude: mostly near one per unit, sometimes anywhere
    function automatic logic [15:0] rand_mag();
        case ($urandom_range(9))
            0:       return V_MAX;
            1:       return '0;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(16'h0C00, 16'h1400));
        endcase
    endfunction

    // one item on the slave side; tvalid stays high into the next item unless a gap is drawn
    task automatic send_item(input logic first, input logic last, input logic line,
                             input logic [15:0] v, input logic [15:0] an,
                             input logic [23:0] gs, input logic [23:0] bs,
                             input logic [23:0] gl, input logic [23:0] bl,
                             input logic [15:0] vo, input logic [15:0] ao);
        if (gaps_on) begin
            while ($urandom_range(99) < 10) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ao, vo, bl, gl, bs, gs, an, v};
        s_axis_tlast  <= last;
        s_axis_tuser  <= {line, first};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
        if (last)
            buses_closed++;
    endtask

    // hold the sender until every queued result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // one bus frame: mostly well formed, some with scrambled framing flags, node voltage and angle
    task automatic random_bus();
        int          n_lines;
        logic        noisy;
        logic        fl, ll, lp;
        logic [15:0] v, an;
        logic [23:0] gs, bs;
        n_lines = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        noisy   = ($urandom_range(99) < 15);
        v       = rand_mag();
        an      = 16'($urandom);
        gs      = rand_adm();
        bs      = rand_adm();
        for (int k = 0; k < n_lines; k++) begin
            fl = (k == 0);
            ll = (k == n_lines - 1);
            lp = ($urandom_range(99) < 92);
            if (noisy) begin
                fl = 1'($urandom_range(1));
                ll = 1'($urandom_range(1));
                lp = 1'($urandom_range(1));
                v  = 16'($urandom);
                an = 16'($urandom);
            end
            send_item(fl, ll, lp, v, an, gs, bs, rand_adm(), rand_adm(), rand_mag(),
                      16'($urandom));
        end
    endtask

    initial begin
        int next_drain;
        items_sent   = 0;
        buses_closed = 0;
        next_drain   = 300;

        // synchronous reset held, then released
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: line term with no first item after reset, sums start from zero
        send_item(1'b0, 1'b1, 1'b1, V_ONE, 16'h0000, '0, '0, ADM_ONE, '0, V_ONE, 16'h0000);
        // shunt-only buses at the voltage and admittance extremes
        send_item(1'b1, 1'b1, 1'b0, V_MAX, 16'h0000, ADM_MAX, ADM_MIN, '0, '0, '0, '0);
        send_item(1'b1, 1'b1, 1'b0, V_MAX, V_MAX, ADM_MIN, ADM_MAX, ADM_MAX, ADM_MIN,
                  V_MAX, V_MAX);
        // result without a first item: sums carry on, shunt fields ignored
        send_item(1'b0, 1'b1, 1'b0, 16'h0000, 16'h1234, ADM_MAX, ADM_MAX, '0, '0, '0, '0);
        // multi-line bus walking the angle difference around the quadrant edges
        send_item(1'b1, 1'b0, 1'b1, V_ONE, 16'h0000, ADM_ONE, 24'hFF0000, ADM_MAX, ADM_MAX,
                  V_MAX, 16'h4000);
        send_item(1'b0, 1'b0, 1'b1, V_ONE, 16'h0000, '0, '0, ADM_MAX, ADM_MIN, V_MAX, 16'h8000);
        send_item(1'b0, 1'b0, 1'b1, V_ONE, 16'h0000, '0, '0, ADM_MIN, ADM_MAX, V_MAX, 16'hC000);
        send_item(1'b0, 1'b0, 1'b1, V_ONE, 16'h0000, '0, '0, ADM_ONE, ADM_ONE, V_ONE, 16'h0001);
        send_item(1'b0, 1'b1, 1'b1, V_ONE, 16'hFFFF, '0, '0, ADM_ONE, ADM_ONE, V_ONE, 16'h0000);
        // single-item buses with voltages and admittances at one end of their range
        send_item(1'b1, 1'b1, 1'b1, V_MAX, V_MAX, ADM_MAX, ADM_MAX, ADM_MAX, ADM_MAX,
                  V_MAX, 16'h0000);
        send_item(1'b1, 1'b1, 1'b1, V_MAX, 16'h2000, ADM_MIN, ADM_MIN, ADM_MIN, ADM_MIN,
                  V_MAX, 16'hE000);
        send_item(1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, ADM_MAX, ADM_MIN, ADM_MAX, ADM_MIN,
                  V_MAX, V_MAX);
        // angle differences just either side of the half-circle turn
        send_item(1'b1, 1'b1, 1'b1, V_ONE, 16'h3FFF, '0, '0, ADM_ONE, ADM_ONE, V_ONE, 16'h0000);
        send_item(1'b1, 1'b1, 1'b1, V_ONE, 16'h4001, '0, '0, ADM_ONE, ADM_ONE, V_ONE, 16'h0000);
        send_item(1'b1, 1'b1, 1'b1, V_ONE, 16'h7FFF, '0, '0, ADM_ONE, ADM_ONE, V_ONE, 16'h0000);
        send_item(1'b1, 1'b1, 1'b1, V_ONE, 16'hBFFF, '0, '0, ADM_ONE, ADM_ONE, V_ONE, 16'h0000);
        // first item with no line, a do-nothing item, then a line that closes the bus
        send_item(1'b1, 1'b0, 1'b0, V_MAX, 16'h0000, ADM_ONE, ADM_ONE, '0, '0, '0, '0);
        send_item(1'b0, 1'b0, 1'b0, V_MAX, V_MAX, ADM_MAX, ADM_MAX, ADM_MAX, ADM_MAX,
                  V_MAX, V_MAX);
        send_item(1'b0, 1'b1, 1'b1, V_MAX, 16'h9000, '0, '0, ADM_MAX, ADM_MIN, 16'h0000,
                  16'h1000);
        // far bus at zero volts
        send_item(1'b1, 1'b1, 1'b1, V_ONE, 16'h5555, ADM_ONE, ADM_ONE, ADM_MAX, ADM_MAX,
                  16'h0000, 16'hAAAA);
        drain_results();

        // random bus frames; a middle stretch runs with no idling on either side
        while (items_sent < RANDOM_ITEMS) begin
            gaps_on  = !(items_sent >= 700 && items_sent < 1100);
            stall_on = gaps_on;
            random_bus();
            if (items_sent >= next_drain) begin
                drain_results();
                next_drain += 300;
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;

        // wait out the outstanding results, then a short quiet tail
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("drove %0d items in %0d bus frames, %0d P/Q results compared", items_sent,
                 buses_closed, results_seen);
        $display("frames mixed framing noise, quadrant-edge angles and admittance extremes");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### ac_bus_power_injection.f
src/acbpi_pkg.sv
src/acbpi_cordic.sv
src/ac_bus_power_injection.sv
sim/acbpi_checker.sv
sim/tb_top.sv
